[hdl/ille_pkg.sv]
// package for the indexed linked list engine: codes and constants
package ille_pkg;
  localparam int unsigned NodesDefault = 1024;
  localparam int unsigned ItemW = 11;
  localparam int unsigned SumW = 19;
  localparam int unsigned LenReset = 1024;

  typedef enum logic [2:0] {
    FN_REBUILD = 3'd0,
    FN_BEFORE  = 3'd1,
    FN_AFTER   = 3'd2,
    FN_SWAP    = 3'd3,
    FN_REVERSE = 3'd4,
    FN_ODDSUM  = 3'd5
  } func_t;
endpackage

[hdl/indexed_linked_list_engine.sv]
// top level of the indexed linked list engine
// Keeps items 1..n in a doubly linked list held in two link memories (next and
// previous per entry, entry 0 the head), with a direction flag for reversal.
// s_axis: one beat per command; tdata = func[2:0], item_x[13:3],
// item_y[24:14], zero filled to 32 bits.
// m_axis: one result beat per command; tdata = odd_sum[18:0], ignored[19].
// cfg_we/cfg_data write list_length, taken by the next rebuild.
// One command at a time: a new command is taken only after the last result
// beat is taken; reverse and ignored commands go straight to the result.
// Move and swap read the link memories for x and then for y, one entry at
// a time with each read waited for, form the joins and then make one link
// write per cycle; rebuild makes two link writes per entry; odd sum walks
// the list by dependent memory reads.
// Reset clears the flag, the built count and the state machine; link memory
// contents are undefined until the first rebuild. Odd sum before any
// rebuild gives an undefined value. A stalled result holds in the output
// register and the block accepts no new command until it is taken.
module indexed_linked_list_engine #(
  parameter int unsigned NODES = ille_pkg::NodesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // func, item_x, item_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // odd_sum, ignored
  input  logic        cfg_we,
  input  logic [10:0] cfg_data        // list_length
);
  import ille_pkg::*;

  localparam int unsigned AW = $clog2(NODES + 1);
  localparam int unsigned NW = $clog2(NODES + 1) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_BUILD, S_RD, S_RDW, S_LOAD, S_WR, S_WALK, S_WALKW, S_OUT
  } state_t;

  // link memories: fwd and bwd per entry
  logic [AW-1:0] fwd_mem [0:NODES];
  logic [AW-1:0] bwd_mem [0:NODES];
  logic [AW-1:0] rd_addr, fwd_q, bwd_q;
  logic          wr_en;
  logic          wr_fwd;
  logic [AW-1:0] wr_addr, wr_data;

  always_ff @(posedge clk) begin
    if (wr_en && wr_fwd) fwd_mem[wr_addr] <= wr_data;
    if (wr_en && !wr_fwd) bwd_mem[wr_addr] <= wr_data;
    fwd_q <= fwd_mem[rd_addr];
    bwd_q <= bwd_mem[rd_addr];
  end

  state_t        state;
  logic [10:0]   list_length;
  logic [NW-1:0] built_n;
  logic          rev;
  func_t         func;
  logic [AW-1:0] x, y;
  logic [AW-1:0] px, nx, py, ny;
  logic [1:0]    rd_idx;
  logic [3:0]    wr_idx;
  logic [3:0]    wr_cnt;
  logic [NW-1:0] cnt;
  logic [AW-1:0] cur;
  logic          odd;
  logic [SumW-1:0] sum;
  logic          ign;
  // join list: up to 8 set operations (addr, data, is next)
  logic [AW-1:0] j_addr [0:7];
  logic [AW-1:0] j_data [0:7];
  logic          j_nxt  [0:7];

  logic [2:0]  in_func;
  logic [10:0] in_x, in_y, len_c;
  logic        in_bad;
  assign in_func = s_axis_tdata[2:0];
  assign in_x    = s_axis_tdata[13:3];
  assign in_y    = s_axis_tdata[24:14];
  assign in_bad  = (in_x == 11'd0) || (in_y == 11'd0) || (in_x == in_y) ||
                   ({{(32-11){1'b0}}, in_x} > 32'(built_n)) ||
                   ({{(32-11){1'b0}}, in_y} > 32'(built_n));
  assign len_c   = (32'(list_length) > NODES) ? 11'(NODES) : list_length;

  // next/prev from raw read data under the direction flag
  logic [AW-1:0] nxt_q, prv_q;
  assign nxt_q = rev ? bwd_q : fwd_q;
  assign prv_q = rev ? fwd_q : bwd_q;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {4'd0, ign, sum};

  // link memory address and write control
  always_comb begin
    rd_addr = cur;
    wr_en   = 1'b0;
    wr_fwd  = 1'b1;
    wr_addr = '0;
    wr_data = '0;
    if (state == S_BUILD) begin
      wr_en   = 1'b1;
      wr_fwd  = odd;
      wr_addr = odd ? cnt[AW-1:0] : AW'(cnt + 1'b1);
      wr_data = odd ? AW'(cnt + 1'b1) : cnt[AW-1:0];
      if (cnt == NW'(len_c)) begin
        wr_addr = odd ? cnt[AW-1:0] : '0;
        wr_data = odd ? '0 : cnt[AW-1:0];
      end
    end else if (state == S_WR) begin
      wr_en   = 1'b1;
      wr_fwd  = j_nxt[wr_idx[2:0]] ^ rev;
      wr_addr = j_addr[wr_idx[2:0]];
      wr_data = j_data[wr_idx[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) list_length <= cfg_data;
    priority case (state)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          func <= func_t'(in_func);
          x    <= AW'(in_x);
          y    <= AW'(in_y);
          sum  <= '0;
          ign  <= 1'b0;
          unique case (in_func)
            FN_REBUILD: begin
              built_n <= NW'(len_c);
              rev     <= 1'b0;
              cnt     <= '0;
              odd     <= 1'b1;
              state   <= S_BUILD;
            end
            FN_BEFORE, FN_AFTER, FN_SWAP: begin
              if (in_bad) begin
                ign   <= 1'b1;
                state <= S_OUT;
              end else begin
                cur    <= AW'(in_x);
                rd_idx <= 2'd0;
                state  <= S_RDW;
              end
            end
            FN_REVERSE: begin
              rev   <= ~rev;
              state <= S_OUT;
            end
            FN_ODDSUM: begin
              cur   <= '0;
              cnt   <= '0;
              state <= S_WALKW;
            end
            default: begin
              ign   <= 1'b1;
              state <= S_OUT;
            end
          endcase
        end
      end
      // two writes per entry: fwd on odd phase, bwd on even
      S_BUILD: begin
        odd <= ~odd;
        if (!odd) begin
          if (cnt == NW'(len_c)) state <= S_OUT;
          else cnt <= cnt + 1'b1;
        end else if (cnt == NW'(len_c)) begin
          odd <= 1'b0;
        end
      end
      // read the neighbors of x, then of y; y's neighbors after unlink are formed in S_LOAD
      S_RDW: state <= S_RD;
      S_RD: begin
        if (rd_idx == 2'd0) begin
          px <= prv_q; nx <= nxt_q;
          cur <= y; rd_idx <= 2'd1; state <= S_RDW;
        end else begin
          py <= prv_q; ny <= nxt_q;
          state <= S_LOAD;
        end
      end
      // build the join list from the gathered neighbors
      S_LOAD: begin
        wr_idx <= '0;
        state  <= S_WR;
        if (func == FN_SWAP) begin
          if (nx == y) begin
            j_addr[0] <= px; j_data[0] <= y;  j_nxt[0] <= 1'b1;
            j_addr[1] <= y;  j_data[1] <= px; j_nxt[1] <= 1'b0;
            j_addr[2] <= y;  j_data[2] <= x;  j_nxt[2] <= 1'b1;
            j_addr[3] <= x;  j_data[3] <= y;  j_nxt[3] <= 1'b0;
            j_addr[4] <= x;  j_data[4] <= ny; j_nxt[4] <= 1'b1;
            j_addr[5] <= ny; j_data[5] <= x;  j_nxt[5] <= 1'b0;
            wr_cnt <= 4'd6;
          end else if (ny == x) begin
            j_addr[0] <= py; j_data[0] <= x;  j_nxt[0] <= 1'b1;
            j_addr[1] <= x;  j_data[1] <= py; j_nxt[1] <= 1'b0;
            j_addr[2] <= x;  j_data[2] <= y;  j_nxt[2] <= 1'b1;
            j_addr[3] <= y;  j_data[3] <= x;  j_nxt[3] <= 1'b0;
            j_addr[4] <= y;  j_data[4] <= nx; j_nxt[4] <= 1'b1;
            j_addr[5] <= nx; j_data[5] <= y;  j_nxt[5] <= 1'b0;
            wr_cnt <= 4'd6;
          end else begin
            j_addr[0] <= px; j_data[0] <= y;  j_nxt[0] <= 1'b1;
            j_addr[1] <= y;  j_data[1] <= px; j_nxt[1] <= 1'b0;
            j_addr[2] <= y;  j_data[2] <= nx; j_nxt[2] <= 1'b1;
            j_addr[3] <= nx; j_data[3] <= y;  j_nxt[3] <= 1'b0;
            j_addr[4] <= py; j_data[4] <= x;  j_nxt[4] <= 1'b1;
            j_addr[5] <= x;  j_data[5] <= py; j_nxt[5] <= 1'b0;
            j_addr[6] <= x;  j_data[6] <= ny; j_nxt[6] <= 1'b1;
            j_addr[7] <= ny; j_data[7] <= x;  j_nxt[7] <= 1'b0;
            wr_cnt <= 4'd8;
          end
        end else begin
          // unlink x, then insert; y's neighbor as seen after unlink
          logic [AW-1:0] py2, ny2;
          py2 = (py == x) ? px : py;
          ny2 = (ny == x) ? nx : ny;
          j_addr[0] <= px; j_data[0] <= nx; j_nxt[0] <= 1'b1;
          j_addr[1] <= nx; j_data[1] <= px; j_nxt[1] <= 1'b0;
          if (func == FN_BEFORE) begin
            j_addr[2] <= py2; j_data[2] <= x;   j_nxt[2] <= 1'b1;
            j_addr[3] <= x;   j_data[3] <= py2; j_nxt[3] <= 1'b0;
            j_addr[4] <= x;   j_data[4] <= y;   j_nxt[4] <= 1'b1;
            j_addr[5] <= y;   j_data[5] <= x;   j_nxt[5] <= 1'b0;
          end else begin
            j_addr[2] <= y;   j_data[2] <= x;   j_nxt[2] <= 1'b1;
            j_addr[3] <= x;   j_data[3] <= y;   j_nxt[3] <= 1'b0;
            j_addr[4] <= x;   j_data[4] <= ny2; j_nxt[4] <= 1'b1;
            j_addr[5] <= ny2; j_data[5] <= x;   j_nxt[5] <= 1'b0;
          end
          wr_cnt <= 4'd6;
        end
      end
      S_WR: begin
        wr_idx <= wr_idx + 1'b1;
        if (wr_idx + 1'b1 == wr_cnt) state <= S_OUT;
      end
      // walk: read cur, then step to its successor
      S_WALKW: state <= S_WALK;
      S_WALK: begin
        if (nxt_q == '0 || 32'(nxt_q) > NODES || 32'(cnt) >= NODES) begin
          state <= S_OUT;
        end else begin
          cnt <= cnt + 1'b1;
          if (!cnt[0]) sum <= sum + SumW'(nxt_q);
          cur   <= nxt_q;
          state <= S_WALKW;
        end
      end
      S_OUT: if (m_axis_tready) state <= S_IDLE;
      default: state <= S_IDLE;
    endcase
    if (rst) begin
      state       <= S_IDLE;
      rev         <= 1'b0;
      built_n     <= '0;
      list_length <= 11'(LenReset);
    end
  end

  assign m_axis_tvalid = (state == S_OUT);

  // a result beat is never shown while a command is being taken
  assert property (@(posedge clk) disable iff (rst)
    !(m_axis_tvalid && s_axis_tready)) else $error("out and in overlap");
  // built count never exceeds the node count
  assert property (@(posedge clk) disable iff (rst)
    32'(built_n) <= NODES) else $error("built count too large");
  // a stalled result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");
endmodule
